/* design/tcce_pkg.sv */
// ----------------------------------------------------------------------------
// tcce_pkg - shared types and constants for the text console cursor engine
// Screen geometry, character codes, action and register codes, state
// encoding and the structs passed between the engine's modules.
// ----------------------------------------------------------------------------
package tcce_pkg;

	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 25;
	localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
	localparam int COPY_COUNT  = CELL_COUNT - SCREEN_COLS;

	localparam int COL_W  = $clog2(SCREEN_COLS);
	localparam int ROW_W  = $clog2(SCREEN_ROWS);
	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int CELL_W = 16;

	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_RETURN  = 8'd13;
	localparam logic [7:0] CH_TAB     = 8'd9;

	// space on light grey
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

	localparam logic [7:0] TEXT_COLOR_RST = 8'd7;
	localparam logic [6:0] TAB_STOP_RST   = 7'd4;

	localparam logic [2:0] ACT_PUT   = 3'd0;
	localparam logic [2:0] ACT_CLEAR = 3'd1;
	localparam logic [2:0] ACT_LEFT  = 3'd2;
	localparam logic [2:0] ACT_RIGHT = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;

	localparam logic REG_TEXT_COLOR = 1'b0;
	localparam logic REG_TAB_STOP   = 1'b1;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_WRITE,
		ST_NEWLINE,
		ST_SCROLL,
		ST_CLEAR,
		ST_DIV,
		ST_MOVE,
		ST_RDWAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  char_code;
		logic [7:0]  move_amount;
		logic        wrap_enable;
		logic [10:0] cell_index;
	} cmd_t;

	typedef struct packed {
		logic [7:0] text_color;
		logic [6:0] tab_stop;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic [4:0]        cursor_row;
		logic [6:0]        cursor_col;
		logic [CELL_W-1:0] cell_value;
		logic              scrolled;
	} res_t;

endpackage

/* design/tcce_ram.sv */
// ----------------------------------------------------------------------------
// tcce_ram - generic simple dual-port RAM
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/tcce_core.sv */
// ----------------------------------------------------------------------------
// tcce_core - cursor sequencer
// Small state machine that owns the cursor, walks the screen store for
// reset fill, clear and scroll, and runs an iterative subtract unit for
// the column/row split of wrapping moves.
// ----------------------------------------------------------------------------
module tcce_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  tcce_pkg::cmd_t     cmd,
	output logic               idle,
	input  tcce_pkg::cfg_t     cfg,
	output tcce_pkg::mem_req_t mem,
	input  logic [15:0]        rd_data,
	input  logic               res_free,
	output logic               res_load,
	output tcce_pkg::res_t     res
);

	import tcce_pkg::*;

	state_t state_q, state_d;

	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	logic [ADDR_W-1:0] base_q, base_d;
	logic [7:0]        rem_q, rem_d;
	logic [7:0]        quo_q, quo_d;
	logic [CELL_W-1:0] cell_q, cell_d;
	logic              scr_q, scr_d;
	cmd_t              cmd_q, cmd_d;

	// write stage: every store write is registered and issued in the cycle after its decision
	logic              wr_vld_s1, wr_vld_d;
	logic [ADDR_W-1:0] wr_addr_s1, wr_addr_d;
	logic [CELL_W-1:0] wr_data_s1, wr_data_d;
	logic              wr_copy_s1, wr_copy_d;

	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;

	// tab
	logic [6:0] tab_t;
	logic [7:0] tab_sum;
	logic [7:0] tab_nc;

	// unwrapped moves
	logic [8:0] sat_sum;

	// wrapped moves
	logic       left_borrow;
	logic [7:0] up_cnt;
	logic [7:0] left_col;
	logic [7:0] right_sum;
	logic       right_carry;
	logic [7:0] down_cnt;
	logic [7:0] right_col;
	logic [7:0] row_ext;
	logic [7:0] row_down;

	assign tab_t   = (cfg.tab_stop == 7'd0) ? 7'd1 : cfg.tab_stop;
	assign tab_sum = 8'(col_q) + 8'(tab_t);
	assign tab_nc  = tab_sum & ~(8'(tab_t) - 8'd1);

	assign sat_sum = 9'(col_q) + 9'(cmd_q.move_amount);

	assign row_ext     = 8'(row_q);
	assign left_borrow = 8'(col_q) < rem_q;
	assign up_cnt      = quo_q + 8'(left_borrow);
	assign left_col    = left_borrow ? 8'(col_q) + 8'(SCREEN_COLS) - rem_q
	                                 : 8'(col_q) - rem_q;
	assign right_sum   = 8'(col_q) + rem_q;
	assign right_carry = right_sum >= 8'(SCREEN_COLS);
	assign down_cnt    = quo_q + 8'(right_carry);
	assign right_col   = right_carry ? right_sum - 8'(SCREEN_COLS) : right_sum;
	assign row_down    = row_ext + down_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			row_q     <= '0;
			col_q     <= '0;
			cnt_q     <= '0;
			wr_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			row_q     <= row_d;
			col_q     <= col_d;
			cnt_q     <= cnt_d;
			wr_vld_s1 <= wr_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		base_q     <= base_d;
		rem_q      <= rem_d;
		quo_q      <= quo_d;
		cell_q     <= cell_d;
		scr_q      <= scr_d;
		cmd_q      <= cmd_d;
		wr_addr_s1 <= wr_addr_d;
		wr_data_s1 <= wr_data_d;
		wr_copy_s1 <= wr_copy_d;
	end

	always_comb begin
		state_d   = state_q;
		row_d     = row_q;
		col_d     = col_q;
		cnt_d     = cnt_q;
		base_d    = base_q;
		rem_d     = rem_q;
		quo_d     = quo_q;
		cell_d    = cell_q;
		scr_d     = scr_q;
		cmd_d     = cmd_q;
		wr_vld_d  = 1'b0;
		wr_addr_d = cnt_q;
		wr_data_d = '0;
		wr_copy_d = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = cnt_q;
		res_load  = 1'b0;

		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				wr_vld_d = 1'b1;
				if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
					cnt_d = '0;
					if (state_q == ST_INIT) begin
						state_d = ST_IDLE;
					end else begin
						row_d   = '0;
						col_d   = '0;
						state_d = ST_DONE;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_d   = cmd;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cell_d = '0;
				scr_d  = 1'b0;
				unique case (cmd_q.action)
					ACT_PUT: begin
						priority if (cmd_q.char_code == CH_NEWLINE) begin
							state_d = ST_NEWLINE;
						end else if (cmd_q.char_code == CH_RETURN) begin
							col_d   = '0;
							state_d = ST_DONE;
						end else if (cmd_q.char_code == CH_TAB) begin
							if (tab_nc >= 8'(SCREEN_COLS)) begin
								state_d = ST_NEWLINE;
							end else begin
								col_d   = COL_W'(tab_nc);
								state_d = ST_DONE;
							end
						end else begin
							base_d  = ADDR_W'(row_q) * ADDR_W'(SCREEN_COLS);
							state_d = ST_WRITE;
						end
					end
					ACT_CLEAR: begin
						cnt_d   = '0;
						state_d = ST_CLEAR;
					end
					ACT_LEFT, ACT_RIGHT: begin
						if (cmd_q.wrap_enable) begin
							rem_d   = cmd_q.move_amount;
							quo_d   = '0;
							state_d = ST_DIV;
						end else begin
							if (cmd_q.action == ACT_LEFT) begin
								col_d = (cmd_q.move_amount <= 8'(col_q))
								      ? COL_W'(8'(col_q) - cmd_q.move_amount) : '0;
							end else begin
								col_d = (sat_sum >= 9'(SCREEN_COLS))
								      ? COL_W'(SCREEN_COLS - 1) : COL_W'(sat_sum);
							end
							state_d = ST_DONE;
						end
					end
					ACT_READ: begin
						if (int'(cmd_q.cell_index) < CELL_COUNT) begin
							rd_en   = 1'b1;
							rd_addr = ADDR_W'(cmd_q.cell_index);
							state_d = ST_RDWAIT;
						end else begin
							state_d = ST_DONE;
						end
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_WRITE: begin
				wr_vld_d  = 1'b1;
				wr_addr_d = base_q + ADDR_W'(col_q);
				wr_data_d = {cfg.text_color, cmd_q.char_code};
				if (col_q == COL_W'(SCREEN_COLS - 1)) begin
					state_d = ST_NEWLINE;
				end else begin
					col_d   = col_q + 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_NEWLINE: begin
				col_d = '0;
				if (row_q == ROW_W'(SCREEN_ROWS - 1)) begin
					scr_d   = 1'b1;
					cnt_d   = '0;
					state_d = ST_SCROLL;
				end else begin
					row_d   = row_q + 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_SCROLL: begin
				// read one row ahead, write back in the next cycle; bottom row gets blanks
				wr_vld_d = 1'b1;
				if (cnt_q < ADDR_W'(COPY_COUNT)) begin
					rd_en     = 1'b1;
					rd_addr   = cnt_q + ADDR_W'(SCREEN_COLS);
					wr_copy_d = 1'b1;
				end else begin
					wr_data_d = BLANK_CELL;
				end
				if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
					cnt_d   = '0;
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DIV: begin
				// one subtract of the line width per cycle
				if (rem_q >= 8'(SCREEN_COLS)) begin
					rem_d = rem_q - 8'(SCREEN_COLS);
					quo_d = quo_q + 8'd1;
				end else begin
					state_d = ST_MOVE;
				end
			end
			ST_MOVE: begin
				if (cmd_q.action == ACT_LEFT) begin
					col_d = COL_W'(left_col);
					row_d = (up_cnt <= row_ext) ? ROW_W'(row_ext - up_cnt) : '0;
				end else begin
					col_d = COL_W'(right_col);
					row_d = (row_down >= 8'(SCREEN_ROWS))
					      ? ROW_W'(SCREEN_ROWS - 1) : ROW_W'(row_down);
				end
				state_d = ST_DONE;
			end
			ST_RDWAIT: begin
				cell_d  = rd_data;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign idle = (state_q == ST_IDLE);

	assign mem.we    = wr_vld_s1;
	assign mem.waddr = wr_addr_s1;
	assign mem.wdata = wr_copy_s1 ? rd_data : wr_data_s1;
	assign mem.re    = rd_en;
	assign mem.raddr = rd_addr;

	assign res.cursor_row = 5'(row_q);
	assign res.cursor_col = 7'(col_q);
	assign res.cell_value = cell_q;
	assign res.scrolled   = scr_q;

endmodule

/* design/text_console_cursor_engine_top.sv */
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top - text console cursor engine
// Screen store of character cells with a cursor, driven one command word
// at a time; every command returns one result word.
// ----------------------------------------------------------------------------
// Command words enter on cmd_valid/cmd_stall, result words leave on
// res_valid/res_stall; a word moves when valid is high and stall is low.
// The engine takes one command at a time and stalls the command side while
// it works. A printable character in the last column, a newline and a tab
// past the line end move the cursor to the next line; on the bottom row
// this scrolls the screen. Wrapped moves split the amount by one subtract
// of the line width per cycle. A scroll or a clear walks every cell once
// through the single store write port.
// The next command is taken the cycle after a result is registered.
// The result register frees the engine from the receiver: a stalled result
// holds, and the engine only blocks if a second result is ready before the
// first has gone.
// After reset the engine fills the store with zeros, one cell a cycle,
// with cmd_stall high until it is done. Registers keep their reset values
// (colour 7, tab stop 4) until written; the cfg port is open at all times.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [2:0]  action,
	input  logic [7:0]  char_code,
	input  logic [7:0]  move_amount,
	input  logic        wrap_enable,
	input  logic [10:0] cell_index,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col,
	output logic [15:0] cell_value,
	output logic        scrolled
);

	import tcce_pkg::*;

	cfg_t       cfg_q;
	cmd_t       cmd;
	mem_req_t   mem;
	res_t       core_res;
	res_t       res_q;
	logic       res_valid_q;
	logic       core_idle;
	logic       core_res_load;
	logic       res_free;
	logic [CELL_W-1:0] rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_color <= TEXT_COLOR_RST;
			cfg_q.tab_stop   <= TAB_STOP_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_TEXT_COLOR) begin
				cfg_q.text_color <= cfg_data;
			end else begin
				cfg_q.tab_stop <= cfg_data[6:0];
			end
		end
	end

	assign cmd.action      = action;
	assign cmd.char_code   = char_code;
	assign cmd.move_amount = move_amount;
	assign cmd.wrap_enable = wrap_enable;
	assign cmd.cell_index  = cell_index;

	assign cmd_stall = !core_idle;
	assign res_free  = !res_valid_q || !res_stall;

	tcce_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.idle      (core_idle),
		.cfg       (cfg_q),
		.mem       (mem),
		.rd_data   (rd_data),
		.res_free  (res_free),
		.res_load  (core_res_load),
		.res       (core_res)
	);

	tcce_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (core_res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_res_load) begin
			res_q <= core_res;
		end
	end

	assign res_valid  = res_valid_q;
	assign cursor_row = res_q.cursor_row;
	assign cursor_col = res_q.cursor_col;
	assign cell_value = res_q.cell_value;
	assign scrolled   = res_q.scrolled;

	// a new result never overwrites one still held by the receiver
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		core_res_load |-> !(res_valid_q && res_stall))
		else $error("result register overwritten while stalled");

	// one command at a time: the engine is busy right after taking a word
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("command taken while previous one in progress");

	// a scroll always leaves the cursor on the bottom row
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && scrolled) |-> (int'(cursor_row) == SCREEN_ROWS - 1))
		else $error("scroll reported off the bottom row");

	// cursor stays on screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (int'(cursor_col) < SCREEN_COLS && int'(cursor_row) < SCREEN_ROWS))
		else $error("cursor outside the screen");

endmodule
